// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers; all checks run on aclk and are off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("go-back-n sender check failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("go-back-n sender check failed");

`endif

// ----- hw/rtl/gbn_pkg.sv -----
`default_nettype none
package gbn_pkg;

    localparam int SEQ_W      = 16;
    localparam int PAY_W      = 64;
    localparam int CNT_W      = 4;
    localparam int WIN_W      = 4;
    localparam int SEQB_W     = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int MAX_BURST  = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_BITS    = 2'd1;

    localparam logic [1:0] KIND_SEND    = 2'd0;
    localparam logic [1:0] KIND_ACK     = 2'd1;
    localparam logic [1:0] KIND_TIMEOUT = 2'd2;

    localparam logic [1:0] TIMER_NONE    = 2'd0;
    localparam logic [1:0] TIMER_START   = 2'd1;
    localparam logic [1:0] TIMER_STOP    = 2'd2;
    localparam logic [1:0] TIMER_RESTART = 2'd3;

    // Command opcodes handed from front to back.
    localparam logic [1:0] OP_SINGLE = 2'd0;
    localparam logic [1:0] OP_SEND   = 2'd1;
    localparam logic [1:0] OP_BURST  = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic             accepted;
        logic             full;
        logic [1:0]       timer;
        logic [SEQ_W-1:0] seq;
        logic [PAY_W-1:0] payload;
        logic [CNT_W-1:0] count;
    } cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/gbn_front.sv -----
`default_nettype none
module gbn_front
    import gbn_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8,
    parameter int SLOT_W = 3
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_take,
    input  wire logic [1:0]            in_kind,
    input  wire logic [PAY_W-1:0]      in_payload,
    input  wire logic [SEQ_W-1:0]      in_ack_num,
    input  wire logic                  in_ack_ok,
    output cmd_t                       cmd,
    output logic [SLOT_W-1:0]          cmd_slot,
    output logic [SEQ_W-1:0]           seq_mask
);

    localparam int SUM_W = SLOT_W + 5;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(WINDOW_DEPTH);

    logic [WIN_W-1:0]  window_size_reg;
    logic [SEQB_W-1:0] seq_bits_reg;
    logic [SEQ_W-1:0]  base_reg, base_next;
    logic [SEQ_W-1:0]  next_seq_reg, next_seq_next;
    logic [SLOT_W-1:0] base_slot_reg, base_slot_next;

    logic [SEQB_W-1:0] bits;
    logic [WIN_W-1:0]  eff;
    logic [SEQ_W-1:0]  cnt, d, after_ack, eff16;
    logic              full_now, ack_hit;
    logic [SUM_W-1:0]  send_sum, ack_sum;

    always_comb begin
        bits = (seq_bits_reg >= 5'd1 && seq_bits_reg <= 5'd16) ? seq_bits_reg : 5'd16;
        seq_mask = 16'hFFFF >> (5'd16 - bits);
        eff = window_size_reg;
        if (eff > WIN_W'(MAX_BURST)) eff = WIN_W'(MAX_BURST);
        if (32'(eff) > WINDOW_DEPTH) eff = WIN_W'(WINDOW_DEPTH);
        if ({12'd0, eff} > seq_mask) eff = seq_mask[WIN_W-1:0];
        if (eff == '0) eff = WIN_W'(1);
        eff16 = {12'd0, eff};
    end

    assign cnt       = (next_seq_reg - base_reg) & seq_mask;
    assign full_now  = cnt >= eff16;
    assign d         = (in_ack_num - base_reg) & seq_mask;
    assign ack_hit   = in_ack_ok && (in_ack_num <= seq_mask) && (d < cnt);
    assign after_ack = cnt - d - 16'd1;
    assign send_sum  = SUM_W'(base_slot_reg) + SUM_W'(cnt[CNT_W-1:0]);
    assign ack_sum   = SUM_W'(base_slot_reg) + SUM_W'(d[CNT_W-1:0]) + SUM_W'(1);

    always_comb begin
        cmd           = '0;
        cmd.op        = OP_SINGLE;
        cmd.full      = full_now;
        cmd.timer     = TIMER_NONE;
        cmd_slot      = base_slot_reg;
        base_next     = base_reg;
        next_seq_next = next_seq_reg;
        base_slot_next = base_slot_reg;
        case (in_kind)
            KIND_SEND: begin
                if (!full_now) begin
                    cmd.op       = OP_SEND;
                    cmd.accepted = 1'b1;
                    cmd.full     = (cnt + 16'd1) >= eff16;
                    cmd.seq      = next_seq_reg;
                    cmd.payload  = in_payload;
                    cmd.timer    = (cnt == '0) ? TIMER_START : TIMER_NONE;
                    cmd_slot     = (send_sum >= DEPTH_S) ? SLOT_W'(send_sum - DEPTH_S)
                                                         : SLOT_W'(send_sum);
                    next_seq_next = (next_seq_reg + 16'd1) & seq_mask;
                end
            end
            KIND_ACK: begin
                if (ack_hit) begin
                    cmd.accepted   = 1'b1;
                    cmd.full       = after_ack >= eff16;
                    cmd.timer      = (after_ack != '0) ? TIMER_RESTART : TIMER_STOP;
                    base_next      = (in_ack_num + 16'd1) & seq_mask;
                    base_slot_next = (ack_sum >= DEPTH_S) ? SLOT_W'(ack_sum - DEPTH_S)
                                                          : SLOT_W'(ack_sum);
                end
            end
            KIND_TIMEOUT: begin
                cmd.timer = TIMER_RESTART;
                if (cnt != '0) begin
                    cmd.op    = OP_BURST;
                    cmd.seq   = base_reg;
                    cmd.count = (cnt > 16'(MAX_BURST)) ? CNT_W'(MAX_BURST)
                                                       : cnt[CNT_W-1:0];
                end
            end
            default: begin
                cmd.op = OP_SINGLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WIN_W'(4);
            seq_bits_reg    <= SEQB_W'(16);
            base_reg        <= '0;
            next_seq_reg    <= '0;
            base_slot_reg   <= '0;
        end else if (cfg_we) begin
            if (cfg_index == CFG_WINDOW_SIZE) begin
                window_size_reg <= cfg_data[WIN_W-1:0];
            end else if (cfg_index == CFG_SEQ_BITS) begin
                // empty the window on a change of sequence space
                seq_bits_reg  <= cfg_data;
                base_reg      <= '0;
                next_seq_reg  <= '0;
                base_slot_reg <= '0;
            end
        end else if (in_take) begin
            base_reg      <= base_next;
            next_seq_reg  <= next_seq_next;
            base_slot_reg <= base_slot_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/gbn_cmd_fifo.sv -----
`default_nettype none
module gbn_cmd_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  head_valid,
    output logic [WIDTH-1:0]      head_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/gbn_back.sv -----
`default_nettype none
module gbn_back
    import gbn_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8,
    parameter int SLOT_W = 3
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              head_valid,
    input  cmd_t                   head_cmd,
    input  wire logic [SLOT_W-1:0] head_slot,
    input  wire logic [SEQ_W-1:0]  seq_mask,
    output logic                   pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_accepted,
    output logic                   m_window_full,
    output logic                   m_tx_valid,
    output logic [SEQ_W-1:0]       m_tx_seq,
    output logic [PAY_W-1:0]       m_tx_payload,
    output logic [1:0]             m_timer_action,
    output logic                   m_last
);

    localparam int SUM_W = SLOT_W + 5;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(WINDOW_DEPTH);

    logic [PAY_W-1:0] mem [WINDOW_DEPTH];
    logic [PAY_W-1:0] mem_q_reg;

    logic [CNT_W-1:0] idx_reg;

    logic             r_valid_reg;
    logic             r_accepted_reg, r_full_reg, r_txv_reg, r_last_reg, r_from_mem_reg;
    logic [SEQ_W-1:0] r_seq_reg;
    logic [PAY_W-1:0] r_payload_reg;
    logic [1:0]       r_timer_reg;

    logic              o_load, r_free, issue, is_burst, beat_last;
    logic [SUM_W-1:0]  bsum;
    logic [SLOT_W-1:0] burst_slot;

    assign o_load     = r_valid_reg && (!m_valid || m_ready);
    assign r_free     = !r_valid_reg || o_load;
    assign issue      = head_valid && r_free;
    assign is_burst   = (head_cmd.op == OP_BURST);
    assign beat_last  = (idx_reg + CNT_W'(1)) == head_cmd.count;
    assign pop        = issue && (!is_burst || beat_last);
    assign bsum       = SUM_W'(head_slot) + SUM_W'(idx_reg);
    assign burst_slot = (bsum >= DEPTH_S) ? SLOT_W'(bsum - DEPTH_S) : SLOT_W'(bsum);

    always_ff @(posedge aclk) begin
        if (issue && head_cmd.op == OP_SEND) begin
            mem[head_slot] <= head_cmd.payload;
        end
        if (issue && is_burst) begin
            mem_q_reg <= mem[burst_slot];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            r_valid_reg <= 1'b0;
            m_valid     <= 1'b0;
        end else begin
            if (issue && is_burst) begin
                idx_reg <= beat_last ? '0 : idx_reg + CNT_W'(1);
            end
            if (r_free) begin
                r_valid_reg <= head_valid;
            end
            if (o_load) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            r_accepted_reg <= head_cmd.accepted;
            r_full_reg     <= head_cmd.full;
            r_from_mem_reg <= is_burst;
            r_payload_reg  <= head_cmd.payload;
            case (head_cmd.op)
                OP_SEND: begin
                    r_txv_reg   <= 1'b1;
                    r_seq_reg   <= head_cmd.seq;
                    r_timer_reg <= head_cmd.timer;
                    r_last_reg  <= 1'b1;
                end
                OP_BURST: begin
                    r_txv_reg   <= 1'b1;
                    r_seq_reg   <= (head_cmd.seq + SEQ_W'(idx_reg)) & seq_mask;
                    r_timer_reg <= beat_last ? head_cmd.timer : TIMER_NONE;
                    r_last_reg  <= beat_last;
                end
                default: begin
                    r_txv_reg   <= 1'b0;
                    r_seq_reg   <= '0;
                    r_timer_reg <= head_cmd.timer;
                    r_last_reg  <= 1'b1;
                end
            endcase
        end
        if (o_load) begin
            m_accepted     <= r_accepted_reg;
            m_window_full  <= r_full_reg;
            m_tx_valid     <= r_txv_reg;
            m_tx_seq       <= r_seq_reg;
            m_tx_payload   <= r_from_mem_reg ? mem_q_reg : r_payload_reg;
            m_timer_action <= r_timer_reg;
            m_last         <= r_last_reg;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/go_back_n_sender_core.sv -----
// Channel  | Direction | Handshake          | Carries
// s_       | in        | s_valid / s_ready  | kind, payload, ack_num, ack_ok
// m_       | out       | m_valid / m_ready  | accepted, window_full, tx_*, timer_action, last
// cfg_     | in        | cfg_valid/cfg_ready| cfg_index (0 window_size, 1 seq_bits), cfg_data
//
// Send, ack, ignored and unknown requests give one result, taken one per cycle while the
// command queue has room; a timeout gives one result per outstanding packet (1 to 8, or
// one if none), one per cycle while m_ready holds, paced by the payload buffer's single
// read port. Results pass through the command queue, result stage and output registers.
// Reset is synchronous on aresetn low and empties the window; no clearing pass is needed.
// A stalled m_ready backs up into a two-entry command queue, then drops s_ready.
`default_nettype none
`include "assert_macros.svh"
module go_back_n_sender_core
    import gbn_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [1:0]            s_kind,
    input  wire logic [PAY_W-1:0]      s_payload,
    input  wire logic [SEQ_W-1:0]      s_ack_num,
    input  wire logic                  s_ack_ok,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_accepted,
    output logic                       m_window_full,
    output logic                       m_tx_valid,
    output logic [SEQ_W-1:0]           m_tx_seq,
    output logic [PAY_W-1:0]           m_tx_payload,
    output logic [1:0]                 m_timer_action,
    output logic                       m_last,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int Q_W    = SLOT_W + $bits(cmd_t);

    cmd_t              f_cmd, h_cmd;
    logic [SLOT_W-1:0] f_slot, h_slot;
    logic [SEQ_W-1:0]  seq_mask;
    logic              q_full, q_valid, q_pop, in_take;

    // Configuration must be written only while idle (unchecked user rule); take it at once.
    assign cfg_ready = 1'b1;
    // Hold the input while the command queue is full.
    assign s_ready   = !q_full;
    assign in_take   = s_valid && s_ready;

    // Front: classify the request, advance window state, emit one command.
    gbn_front #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .SLOT_W(SLOT_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_take   (in_take),
        .in_kind   (s_kind),
        .in_payload(s_payload),
        .in_ack_num(s_ack_num),
        .in_ack_ok (s_ack_ok),
        .cmd       (f_cmd),
        .cmd_slot  (f_slot),
        .seq_mask  (seq_mask)
    );

    // Queue: decouple command generation from result delivery.
    gbn_cmd_fifo #(
        .WIDTH(Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_take),
        .push_data ({f_slot, f_cmd}),
        .pop       (q_pop),
        .full      (q_full),
        .head_valid(q_valid),
        .head_data ({h_slot, h_cmd})
    );

    // Back: store payloads, replay the window on timeout, drive results.
    gbn_back #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .SLOT_W(SLOT_W)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (q_valid),
        .head_cmd      (h_cmd),
        .head_slot     (h_slot),
        .seq_mask      (seq_mask),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_accepted    (m_accepted),
        .m_window_full (m_window_full),
        .m_tx_valid    (m_tx_valid),
        .m_tx_seq      (m_tx_seq),
        .m_tx_payload  (m_tx_payload),
        .m_timer_action(m_timer_action),
        .m_last        (m_last)
    );

    // Checks: replay beats run back to back, accepted results end their request,
    // a timer start comes only with a new packet, the queue never overflows.
    `ASSERT_NXT(a_burst_continues, m_valid && m_ready && !m_last, m_valid)
    `ASSERT_IMP(a_accepted_last, m_valid && m_accepted, m_last)
    `ASSERT_IMP(a_start_with_send, m_valid && m_timer_action == TIMER_START,
                m_tx_valid && m_accepted)
    `ASSERT_IMP(a_no_overflow, in_take, !q_full || q_pop)

endmodule
`default_nettype wire
